>>> rtl/ltd_pkg.sv
// Shared types, codes and reset constants for the length/XOR/tail frame receiver.
package ltd_pkg;

  // Default tail length in bytes
  localparam int TAIL_BYTES_DEF = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYTE_TIME  = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TAIL_WORD  = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  BYTE_TIME_RST  = 8'd1;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd256;
  localparam logic [23:0] TAIL_WORD_RST  = 24'h454E44;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_ERROR  = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_time_ms;
    logic [15:0] max_length;
    logic [23:0] tail_word;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] message_length;
  } result_t;

  // Handshake between the core and the result register
  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

endpackage

>>> rtl/ltd_if.sv
// Valid/ready channel interfaces for received items and results.
interface ltd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface ltd_out_if import ltd_pkg::*; ;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [15:0] message_length;

  modport source (output valid, output status, output payload_byte, output byte_index,
                  output message_length, input ready);
  modport sink   (input valid, input status, input payload_byte, input byte_index,
                  input message_length, output ready);
endinterface

>>> rtl/length_xor_tail_deframer.sv
// Top level of the length/XOR/tail frame receiver.
// Takes one transaction per clock (a received byte or a millisecond tick) and
// reports each payload byte, then one frame status, in order. A transaction is
// held in the input register and processed combinationally by the frame state
// machine, which loads its result, if any, into the result register; a new
// transaction is taken every cycle while the result register is free or being
// drained. A frame is a big-endian 16-bit length, the payload (ending in two
// parity bytes, XOR of big-endian byte pairs must be zero) and TAIL_BYTES tail
// bytes compared against tail_word. Each phase times out after byte_time_ms
// ticks per byte. The user must write configuration only while idle; the block
// itself does not enforce it. Configuration needs no settling time after reset.
module length_xor_tail_deframer import ltd_pkg::*; #(
  parameter int TAIL_BYTES = TAIL_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ltd_in_if.sink      in_chan,
  ltd_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  cfg_t      cfg;
  logic      stg_valid;
  item_t     stg_item;
  logic      consume;
  logic      out_free;
  res_push_t res_push;

  ltd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ltd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .consume   (consume),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  ltd_core #(.TAIL_BYTES(TAIL_BYTES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .out_free  (out_free),
    .consume   (consume),
    .res_out   (res_push)
  );

  ltd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_in   (res_push),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/ltd_cfg_regs.sv
// Configuration registers written through the plain write port.
module ltd_cfg_regs import ltd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BYTE_TIME:  cfg_nxt.byte_time_ms = cfg_wdata[7:0];
        CFG_MAX_LENGTH: cfg_nxt.max_length   = cfg_wdata[15:0];
        CFG_TAIL_WORD:  cfg_nxt.tail_word    = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_time_ms <= BYTE_TIME_RST;
      cfg_r.max_length   <= MAX_LENGTH_RST;
      cfg_r.tail_word    <= TAIL_WORD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/ltd_in_stage.sv
// Input register: holds one accepted transaction until the core consumes it.
module ltd_in_stage import ltd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ltd_in_if.sink in_chan,
  input  logic consume,
  output logic stg_valid,
  output item_t stg_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Accept when empty or when the held transaction leaves this cycle
  assign in_chan.ready = !valid_r || consume;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.command   <= in_chan.command;
      item_r.data_byte <= in_chan.data_byte;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

>>> rtl/ltd_core.sv
// Frame state machine: header, payload with XOR check, tail compare and timeouts.
module ltd_core import ltd_pkg::*; #(
  parameter int TAIL_BYTES = TAIL_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      stg_valid,
  input  item_t     stg_item,
  input  logic      out_free,
  output logic      consume,
  output res_push_t res_out
);

  localparam int          TAIL_CMP  = (TAIL_BYTES >= 3) ? 3 : TAIL_BYTES;
  localparam logic [23:0] TAIL_MASK = 24'((64'(1) << (8 * TAIL_CMP)) - 64'(1));
  localparam logic [15:0] TAIL_CNT  = 16'(TAIL_BYTES);

  phase_t      phase_r,  phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] flen_r,   flen_nxt;
  logic [15:0] rcnt_r,   rcnt_nxt;
  logic [15:0] par_r,    par_nxt;
  logic [23:0] tail_r,   tail_nxt;
  logic [23:0] elap_r,   elap_nxt;
  logic [23:0] win_r,    win_nxt;

  logic        res_valid;
  result_t     res;
  logic [15:0] hdr_len;
  logic [15:0] par_upd;
  logic [15:0] rcnt_inc;
  logic [23:0] elap_inc;
  logic [23:0] tail_upd;
  logic [15:0] win_count;
  logic [23:0] win_prod;

  // Shared terms of the update
  assign hdr_len  = {len_hi_r, stg_item.data_byte};
  assign par_upd  = par_r ^ (rcnt_r[0] ? {8'd0, stg_item.data_byte}
                                       : {stg_item.data_byte, 8'd0});
  assign rcnt_inc = rcnt_r + 16'd1;
  assign elap_inc = elap_r + 24'd1;
  assign tail_upd = {tail_r[15:0], stg_item.data_byte};

  // Byte count of the window that starts with this byte
  always_comb begin
    case (phase_r)
      PH_IDLE:    win_count = 16'd2;
      PH_HEADER:  win_count = hdr_len;
      default:    win_count = TAIL_CNT;
    endcase
  end

  assign win_prod = {16'd0, cfg.byte_time_ms} * {8'd0, win_count};

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    flen_nxt   = flen_r;
    rcnt_nxt   = rcnt_r;
    par_nxt    = par_r;
    tail_nxt   = tail_r;
    elap_nxt   = elap_r;
    win_nxt    = win_r;
    res_valid  = 1'b0;
    res        = '{status: ST_BYTE, payload_byte: 8'd0, byte_index: 16'd0,
                   message_length: 16'd0};

    if (stg_item.command == CMD_TICK) begin
      // Advance the timeout window, end the frame when it runs out
      if (phase_r != PH_IDLE) begin
        elap_nxt = elap_inc;
        if (elap_inc >= win_r) begin
          phase_nxt  = PH_IDLE;
          res_valid  = 1'b1;
          res.status = (phase_r == PH_HEADER) ? ST_REJECT : ST_ERROR;
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          len_hi_nxt = stg_item.data_byte;
          phase_nxt  = PH_HEADER;
          elap_nxt   = 24'd0;
          win_nxt    = win_prod;
        end
        PH_HEADER: begin
          flen_nxt = hdr_len;
          if (hdr_len == 16'd0 || hdr_len >= cfg.max_length) begin
            phase_nxt  = PH_IDLE;
            res_valid  = 1'b1;
            res.status = ST_REJECT;
          end else begin
            rcnt_nxt  = 16'd0;
            par_nxt   = 16'd0;
            phase_nxt = PH_PAYLOAD;
            elap_nxt  = 24'd0;
            win_nxt   = win_prod;
          end
        end
        PH_PAYLOAD: begin
          par_nxt          = par_upd;
          rcnt_nxt         = rcnt_inc;
          res_valid        = 1'b1;
          res.payload_byte = stg_item.data_byte;
          res.byte_index   = rcnt_r;
          if (rcnt_inc >= flen_r) begin
            if (par_upd != 16'd0) begin
              // Parity failure replaces the last byte's report
              phase_nxt        = PH_IDLE;
              res.status       = ST_ERROR;
              res.payload_byte = 8'd0;
              res.byte_index   = 16'd0;
            end else begin
              rcnt_nxt  = 16'd0;
              tail_nxt  = 24'd0;
              phase_nxt = PH_TAIL;
              elap_nxt  = 24'd0;
              win_nxt   = win_prod;
            end
          end
        end
        default: begin
          tail_nxt = tail_upd;
          rcnt_nxt = rcnt_inc;
          if (rcnt_inc >= TAIL_CNT) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            if ((tail_upd & TAIL_MASK) != (cfg.tail_word & TAIL_MASK)) begin
              res.status = ST_ERROR;
            end else begin
              res.status         = ST_GOOD;
              res.message_length = (flen_r >= 16'd2) ? flen_r - 16'd2 : 16'd0;
            end
          end
        end
      endcase
    end
  end

  // Consume when there is room for any result this transaction makes
  assign consume        = stg_valid && (out_free || !res_valid);
  assign res_out.push   = consume && res_valid;
  assign res_out.res    = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      len_hi_r <= 8'd0;
      flen_r   <= 16'd0;
      rcnt_r   <= 16'd0;
      par_r    <= 16'd0;
      tail_r   <= 24'd0;
      elap_r   <= 24'd0;
      win_r    <= 24'd0;
    end else if (consume) begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      flen_r   <= flen_nxt;
      rcnt_r   <= rcnt_nxt;
      par_r    <= par_nxt;
      tail_r   <= tail_nxt;
      elap_r   <= elap_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule

>>> rtl/ltd_out_reg.sv
// Result register: holds one result transaction until the sink takes it.
module ltd_out_reg import ltd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t res_in,
  output logic      out_free,
  ltd_out_if.source out_chan
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_in.push) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (res_in.push) begin
      res_r <= res_in.res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.status         = res_r.status;
  assign out_chan.payload_byte   = res_r.payload_byte;
  assign out_chan.byte_index     = res_r.byte_index;
  assign out_chan.message_length = res_r.message_length;

endmodule

>>> rtl/ltd_checker.sv
// Port-level checks on the frame receiver, bound to the top level.
module ltd_checker import ltd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input status_t     out_status,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_byte_index,
  input logic [15:0] out_message_length
);

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Byte fields are zero on frame status results
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_payload_byte == 8'd0 && out_byte_index == 16'd0)
    else $error("byte fields set on a status result");

  // Message length appears only on a good frame
  a_len_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GOOD |-> out_message_length == 16'd0)
    else $error("message length outside a good frame");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_payload_byte) && $stable(out_byte_index)
      && $stable(out_message_length))
    else $error("stalled result changed");

endmodule

bind length_xor_tail_deframer ltd_checker u_ltd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_status         (out_chan.status),
  .out_payload_byte   (out_chan.payload_byte),
  .out_byte_index     (out_chan.byte_index),
  .out_message_length (out_chan.message_length)
);

>>> tb/sv/ltd_frame_tracker_pkg.sv
`timescale 1ns / 100ps
// Frame tracker for the deframer testbench: mirrors the receiver and checks its reports.
package ltd_frame_tracker_pkg;
  import ltd_pkg::*;

  class deframe_tracker;
    // Register copies
    logic [7:0]  byte_time_ms;
    logic [15:0] max_length;
    logic [23:0] tail_word;

    // Receiver state
    phase_t      phase;
    logic [7:0]  length_high;
    logic [15:0] frame_length;
    logic [15:0] received_count;
    logic [15:0] parity_acc;
    logic [23:0] tail_shift;
    logic [23:0] elapsed_ticks;
    logic [23:0] window_ticks;

    // Reports still owed by the block, oldest first
    result_t     pending_reports[$];
    int unsigned mismatches;
    int unsigned status_seen[4];

    function new();
      byte_time_ms   = BYTE_TIME_RST;
      max_length     = MAX_LENGTH_RST;
      tail_word      = TAIL_WORD_RST;
      phase          = PH_IDLE;
      length_high    = '0;
      frame_length   = '0;
      received_count = '0;
      parity_acc     = '0;
      tail_shift     = '0;
      elapsed_ticks  = '0;
      window_ticks   = '0;
      mismatches     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [23:0] value);
      case (index)
        CFG_BYTE_TIME:  byte_time_ms = value[7:0];
        CFG_MAX_LENGTH: max_length   = value[15:0];
        CFG_TAIL_WORD:  tail_word    = value;
        default: ;
      endcase
    endfunction

    // Restart the phase timer for a phase of the given byte count
    function void open_window(logic [15:0] count);
      elapsed_ticks = '0;
      window_ticks  = byte_time_ms * count;
    endfunction

    function void owe_report(status_t st, logic [7:0] b, logic [15:0] idx,
                             logic [15:0] len);
      result_t r;
      r.status         = st;
      r.payload_byte   = b;
      r.byte_index     = idx;
      r.message_length = len;
      pending_reports.push_back(r);
    endfunction

    // Note one accepted transaction and queue the report it causes, if any
    function void take_item(item_t it);
      logic [15:0] idx;
      if (it.command == CMD_TICK) begin
        if (phase == PH_IDLE) return;
        elapsed_ticks = elapsed_ticks + 24'd1;
        if (elapsed_ticks < window_ticks) return;
        owe_report(phase == PH_HEADER ? ST_REJECT : ST_ERROR, '0, '0, '0);
        phase = PH_IDLE;
        return;
      end
      case (phase)
        PH_IDLE: begin
          length_high = it.data_byte;
          phase       = PH_HEADER;
          open_window(16'd2);
        end
        PH_HEADER: begin
          frame_length = {length_high, it.data_byte};
          if (frame_length == 16'd0 || frame_length >= max_length) begin
            phase = PH_IDLE;
            owe_report(ST_REJECT, '0, '0, '0);
          end else begin
            received_count = '0;
            parity_acc     = '0;
            phase          = PH_PAYLOAD;
            open_window(frame_length);
          end
        end
        PH_PAYLOAD: begin
          idx = received_count;
          // Even positions fold into the high byte, odd into the low byte
          if (idx[0]) parity_acc = parity_acc ^ {8'h00, it.data_byte};
          else parity_acc = parity_acc ^ {it.data_byte, 8'h00};
          received_count = received_count + 16'd1;
          if (received_count >= frame_length) begin
            if (parity_acc != 16'd0) begin
              phase = PH_IDLE;
              owe_report(ST_ERROR, '0, '0, '0);
              return;
            end
            received_count = '0;
            tail_shift     = '0;
            phase          = PH_TAIL;
            open_window(16'(TAIL_BYTES_DEF));
          end
          owe_report(ST_BYTE, it.data_byte, idx, '0);
        end
        default: begin
          tail_shift     = {tail_shift[15:0], it.data_byte};
          received_count = received_count + 16'd1;
          if (received_count < 16'(TAIL_BYTES_DEF)) return;
          phase = PH_IDLE;
          // Three tail bytes: the whole tail word takes part
          if (tail_shift != tail_word) owe_report(ST_ERROR, '0, '0, '0);
          else owe_report(ST_GOOD, '0, '0,
                          frame_length >= 16'd2 ? frame_length - 16'd2 : 16'd0);
        end
      endcase
    endfunction

    // Compare one accepted report against the oldest one owed
    function void check_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected report: status %0d, byte %0h, index %0d, length %0d",
               got.status, got.payload_byte, got.byte_index, got.message_length);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      status_seen[int'(want.status)]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        mismatches++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        mismatches++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, got %0d",
               want.message_length, got.message_length);
        mismatches++;
      end
    endfunction

    function bit all_reported();
      return pending_reports.size() == 0;
    endfunction
  endclass

endpackage

>>> tb/sv/length_xor_tail_deframer_test.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, stimulus, report checking and run verdict.
module length_xor_tail_deframer_test;
  import ltd_pkg::*;
  import ltd_frame_tracker_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;

  ltd_in_if  in_chan ();
  ltd_out_if out_chan ();

  length_xor_tail_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframe_tracker tracker = new();
  int unsigned    items_sent;
  int unsigned    burst_left;
  int unsigned    settings_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #5000000;
    $display("length_xor_tail_deframer_test: done, errors");
    $finish;
  end

  // Receiver: stall on a ready mask that is picked anew at regular intervals
  initial begin
    logic [15:0] ready_mask;
    int unsigned cycle_n;
    out_chan.ready = 1'b0;
    ready_mask     = 16'hFFFF;
    cycle_n        = 0;
    forever begin
      @(negedge clk);
      if (cycle_n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mask = 16'hFFFF;
          1: ready_mask = 16'($urandom_range(0, 65535)) | 16'h0001;
          2: ready_mask = 16'h00FF;
          default: ready_mask = 16'h5555;
        endcase
      end
      out_chan.ready = ready_mask[cycle_n % 16];
      cycle_n++;
    end
  end

  // Check every accepted report
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.status         = out_chan.status;
      got.payload_byte   = out_chan.payload_byte;
      got.byte_index     = out_chan.byte_index;
      got.message_length = out_chan.message_length;
      tracker.check_report(got);
    end
  end

  // Offer one transaction, in bursts with random gaps; entered and left at a falling edge
  task automatic send_item(logic cmd, logic [7:0] b);
    item_t it;
    it.command   = cmd;
    it.data_byte = b;
    if (burst_left == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
    in_chan.valid     = 1'b1;
    in_chan.command   = cmd;
    in_chan.data_byte = b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    // Ticks while idle do nothing and do not count
    if (!(cmd == CMD_TICK && tracker.phase == PH_IDLE)) items_sent++;
    tracker.take_item(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic put_byte(logic [7:0] b);
    send_item(CMD_BYTE, b);
  endtask

  task automatic put_tick();
    send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic maybe_tick(int unsigned pct);
    if ($urandom_range(0, 99) < pct) put_tick();
  endtask

  // Hold the sender until every owed report has come, then let the pipeline empty
  task automatic drain_reports();
    in_chan.valid = 1'b0;
    while (!tracker.all_reported()) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [23:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(index, value);
  endtask

  task automatic apply_setting(logic [7:0] bt, logic [15:0] max_len, logic [23:0] tail);
    drain_reports();
    write_register(CFG_BYTE_TIME, {16'h0000, bt});
    write_register(CFG_MAX_LENGTH, {8'h00, max_len});
    write_register(CFG_TAIL_WORD, tail);
    settings_done++;
  endtask

  // Send a whole frame; parity bytes cancel the XOR unless told to spoil it
  task automatic send_frame(int unsigned len, bit bad_parity, bit bad_tail,
                            int unsigned tick_pct);
    logic [7:0]  body[$];
    logic [15:0] acc;
    logic [15:0] len16;
    logic [23:0] tail;
    len16 = 16'(len);
    acc   = '0;
    for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    if (len >= 2) begin
      for (int i = 0; i < len - 2; i++) begin
        if (i % 2 == 1) acc = acc ^ {8'h00, body[i]};
        else acc = acc ^ {body[i], 8'h00};
      end
      if ((len - 2) % 2 == 0) begin
        body[len-2] = acc[15:8];
        body[len-1] = acc[7:0];
      end else begin
        body[len-2] = acc[7:0];
        body[len-1] = acc[15:8];
      end
    end else begin
      body[0] = 8'h00;
    end
    if (bad_parity) body[len-1] = body[len-1] ^ 8'($urandom_range(1, 255));
    tail = tracker.tail_word;
    if (bad_tail) tail = tail ^ (24'd1 << $urandom_range(0, 23));
    put_byte(len16[15:8]);
    maybe_tick(tick_pct);
    put_byte(len16[7:0]);
    foreach (body[i]) begin
      maybe_tick(tick_pct);
      put_byte(body[i]);
    end
    for (int i = 2; i >= 0; i--) begin
      maybe_tick(tick_pct);
      put_byte(tail[8*i +: 8]);
    end
  endtask

  // Bring the receiver back to idle by bytes or by timing out the phase
  task automatic settle_frame(bit prefer_timeout);
    int ticks_left;
    int bytes_left;
    while (tracker.phase != PH_IDLE) begin
      ticks_left = int'(tracker.window_ticks) - int'(tracker.elapsed_ticks);
      case (tracker.phase)
        PH_HEADER:  bytes_left = 1;
        PH_PAYLOAD: bytes_left = int'(tracker.frame_length) - int'(tracker.received_count);
        default:    bytes_left = TAIL_BYTES_DEF - int'(tracker.received_count);
      endcase
      if (prefer_timeout ? (ticks_left <= 64) : (ticks_left < bytes_left)) put_tick();
      else put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise
  task automatic run_phase(int unsigned budget, int unsigned tick_pct);
    int unsigned stop_at;
    int unsigned half_at;
    int unsigned pick;
    int          len_cap;
    int          long_cap;
    int          len;
    bit          drained;
    stop_at  = items_sent + budget;
    half_at  = items_sent + budget / 2;
    drained  = 1'b0;
    len_cap  = int'(tracker.max_length) - 1;
    long_cap = (len_cap < 200) ? len_cap : 200;
    if (len_cap > 24) len_cap = 24;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, long_cap)
                                          : $urandom_range(1, len_cap);
      if (pick < 13) begin
        send_frame(len, 1'b0, 1'b0, tick_pct);
      end else if (pick < 15) begin
        send_frame(len, 1'b1, 1'b0, tick_pct);
      end else if (pick < 16) begin
        send_frame(len, 1'b0, 1'b1, tick_pct);
      end else if (pick < 17) begin
        // Header that must be refused
        case ($urandom_range(0, 2))
          0: len = 0;
          1: len = int'(tracker.max_length);
          default: len = $urandom_range(int'(tracker.max_length), 65535);
        endcase
        put_byte(8'(len >> 8));
        put_byte(8'(len));
      end else if (pick < 18) begin
        // Cut a frame short and let it time out
        put_byte(8'(len >> 8));
        put_byte(8'(len));
        repeat ($urandom_range(0, len)) put_byte(8'($urandom_range(0, 255)));
        settle_frame(1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      if (!drained && items_sent >= half_at) begin
        drain_reports();
        drained = 1'b1;
      end
    end
    settle_frame(1'b0);
  endtask

  // Stimulus
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.command   = CMD_BYTE;
    in_chan.data_byte = 8'h00;
    cfg_we            = 1'b0;
    cfg_index         = CFG_BYTE_TIME;
    cfg_wdata         = '0;
    items_sent        = 0;
    burst_left        = 0;
    settings_done     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at the reset settings
    put_tick();                                           // tick while idle
    put_byte(8'h00); put_byte(8'h00);                     // zero length
    put_byte(8'h01); put_byte(8'h00);                     // length at the limit
    put_byte(8'h00); put_byte(8'h01); put_byte(8'h00);    // length of one, good
    put_byte(8'h45); put_byte(8'h4E); put_byte(8'h44);
    put_byte(8'h00); put_byte(8'h02);                     // parity failure
    put_byte(8'hFF); put_byte(8'h00);
    put_byte(8'hFF); put_tick(); put_tick();              // header timeout
    put_byte(8'h00); put_byte(8'h02); put_byte(8'hAA);    // payload timeout
    put_tick(); put_tick();
    put_byte(8'h00); put_byte(8'h01); put_byte(8'h00);    // tail mismatch
    put_byte(8'h45); put_byte(8'h4E); put_byte(8'h45);
    run_phase(230, 8);

    // Zero byte time, widest length limit: a huge frame ends on the first tick
    apply_setting(8'd0, 16'hFFFF, 24'hFFFFFF);
    put_byte(8'hFF); put_byte(8'hFE); put_byte(8'h12); put_byte(8'h34);
    put_tick();
    run_phase(230, 3);

    apply_setting(8'd255, 16'd2, 24'h000000);
    run_phase(200, 10);
    apply_setting(8'd1, 16'd40, 24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(230, 10);
    apply_setting(8'd3, 16'd12, 24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(230, 15);
    apply_setting(8'd2, 16'd300, 24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(230, 8);
    apply_setting(8'($urandom_range(1, 4)), 16'($urandom_range(2, 64)),
                  24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(230, 10);
    apply_setting(8'($urandom_range(1, 255)), 16'($urandom_range(2, 65535)),
                  24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(230, 8);

    // Wait out the last reports, then give the verdict
    drain_reports();
    repeat (8) @(negedge clk);
    $display("Covered %0d transactions over %0d register settings after reset.",
             items_sent, settings_done + 1);
    $display("Reports checked: %0d payload bytes, %0d good, %0d transfer errors, %0d refused.",
             tracker.status_seen[ST_BYTE], tracker.status_seen[ST_GOOD],
             tracker.status_seen[ST_ERROR], tracker.status_seen[ST_REJECT]);
    if (tracker.mismatches == 0 && tracker.all_reported()) begin
      $display("length_xor_tail_deframer_test: done, clean");
    end else begin
      $display("length_xor_tail_deframer_test: done, errors");
    end
    $finish;
  end

endmodule
